>>> hw/rtl/time_source_consensus_voter_macros.svh
// Assertion macros shared by the voter RTL.
// Included by files that carry concurrent assertions.
`ifndef TIME_SOURCE_CONSENSUS_VOTER_MACROS_SVH
`define TIME_SOURCE_CONSENSUS_VOTER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TSCV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define TSCV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/tscv_pkg.sv
// Package for the time source consensus voter: sizes, codes and types.
// No dependencies.
package tscv_pkg;
  localparam int PoolSize = 4;
  localparam int IdxW = $clog2(PoolSize);
  localparam int CntW = $clog2(PoolSize + 1);

  localparam logic [1:0] CfgWindow    = 2'd0;
  localparam logic [1:0] CfgMaxJump   = 2'd1;
  localparam logic [1:0] CfgThreshold = 2'd2;

  localparam logic [0:0] OpPropose = 1'b0;
  localparam logic [0:0] OpEnd     = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_PAIR     = 3'd1,
    ST_ADJUSTED = 3'd2,
    ST_REJECTED = 3'd3,
    ST_RESEEDED = 3'd4,
    ST_SINGLE   = 3'd5,
    ST_WITHHELD = 3'd6,
    ST_WAITING  = 3'd7
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] src_key;
    logic [31:0] proposed_time;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic        set_clock;
    logic [31:0] clock_value;
    logic        is_synced;
    status_t     status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  index;
  } cfg_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASSIFY,
    S_SLOT,
    S_CPAIR,
    S_CDIST,
    S_DSLOT,
    S_DPAIR,
    S_EOA,
    S_OUT
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;        // capture request
    logic cand_slot;   // allocate/select candidate slot
    logic cand_scan;   // test one candidate against new proposal
    logic cand_mark;   // mark distrust for one candidate
    logic dist_slot;   // allocate distrust slot and count reject
    logic dist_scan;   // test one distrust pair
    logic eoa;         // end-of-attempt evaluation
    logic adjust;      // apply synced jump
    logic reject;      // finish as rejected
    logic step_i;      // advance scan index i
    logic step_j;      // advance scan index j (wrap to i+2 pattern)
    logic clr_idx;
  } cmd_t;

  typedef struct packed {
    logic       synced;
    logic       is_end;
    logic       jump_ok;
    logic       hit;        // last scan found a match
    logic       i_last;     // i scan exhausted
    logic       j_last;     // j scan exhausted for this i
    logic       thr_met;
  } sts_t;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction
endpackage

>>> hw/rtl/tscv_if.sv
// Valid/ready channel interfaces for the voter.
// Depends on tscv_pkg.
interface tscv_in_if;
  import tscv_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tscv_out_if;
  import tscv_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tscv_cfg_if;
  import tscv_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/tscv_ctrl.sv
// Controller state machine of the voter: sequences scans over the pools.
// Depends on tscv_pkg and the macros header.
`include "time_source_consensus_voter_macros.svh"
module tscv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tscv_pkg::sts_t  sts,
  output tscv_pkg::cmd_t  cmd
);
  import tscv_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        cmd.clr_idx = 1'b1;
        if (sts.is_end) begin
          state_nxt = sts.synced ? S_OUT : S_EOA;
        end else if (!sts.synced) begin
          state_nxt = S_SLOT;
        end else if (sts.jump_ok) begin
          cmd.adjust = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DSLOT;
        end
      end
      S_SLOT: begin
        cmd.cand_slot = 1'b1;
        state_nxt = S_CPAIR;
      end
      S_CPAIR: begin
        cmd.cand_scan = 1'b1;
        cmd.step_i = 1'b1;
        if (sts.hit) begin
          state_nxt = S_OUT;
        end else if (sts.i_last) begin
          cmd.clr_idx = 1'b1;
          cmd.step_i = 1'b0;
          state_nxt = S_CDIST;
        end
      end
      S_CDIST: begin
        cmd.cand_mark = 1'b1;
        cmd.step_i = 1'b1;
        if (sts.i_last) begin
          state_nxt = S_OUT;
        end
      end
      S_DSLOT: begin
        cmd.dist_slot = 1'b1;
        state_nxt = S_DPAIR;
      end
      S_DPAIR: begin
        if (!sts.thr_met) begin
          cmd.reject = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.dist_scan = 1'b1;
          if (sts.hit) begin
            state_nxt = S_OUT;
          end else if (sts.j_last) begin
            cmd.step_i = 1'b1;
            if (sts.i_last) begin
              cmd.reject = 1'b1;
              state_nxt = S_OUT;
            end
          end else begin
            cmd.step_j = 1'b1;
          end
        end
      end
      S_EOA: begin
        cmd.eoa = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `TSCV_ASSERT_IMP(a_rdy_idle, in_ready, state_r == S_IDLE)
  `TSCV_ASSERT_IMP(a_excl, in_ready, !out_valid)
  `TSCV_ASSERT_NXT(a_load, in_valid && in_ready, state_r == S_CLASSIFY)
endmodule

>>> hw/rtl/tscv_dp.sv
// Datapath of the voter: pools, counters, config registers and result.
// Depends on tscv_pkg and the macros header.
`include "time_source_consensus_voter_macros.svh"
module tscv_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tscv_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  tscv_pkg::cfg_item_t  cfg_data,
  input  tscv_pkg::cmd_t       cmd,
  output tscv_pkg::sts_t       sts,
  output tscv_pkg::out_item_t  out_data
);
  import tscv_pkg::*;

  logic [15:0] win_r;
  logic [31:0] jump_r;
  logic [7:0]  thr_r;

  in_item_t    req_r;
  logic [PoolSize-1:0] cv_r, cresp_r, cdist_r;
  logic [31:0] csrc_r [PoolSize];
  logic [31:0] ctim_r [PoolSize];
  logic [15:0] cage_r [PoolSize];
  logic [CntW-1:0] ccnt_r;
  logic [PoolSize-1:0] dv_r;
  logic [31:0] dsrc_r [PoolSize];
  logic [31:0] dtim_r [PoolSize];
  logic [15:0] dage_r [PoolSize];
  logic [CntW-1:0] dcnt_r;
  logic [7:0]  rej_r, att_r;
  logic        sync_r;
  logic [15:0] seq_r;
  logic [IdxW-1:0] s_r, i_r, j_r;
  out_item_t   res_r;

  // combinational helpers
  logic [CntW:0] i_ext, j_ext;
  logic [31:0] cdiff, ddiff;
  logic        chit, dhit;
  logic [IdxW-1:0] c_match, c_free, c_old, d_match, d_old, first;
  logic        c_found, c_hasfree, d_found;
  logic [15:0] best_el, el;
  logic [15:0] dbest_el, del;
  logic [CntW-1:0] nresp;

  assign i_ext = {1'b0, CntW'(i_r)};
  assign j_ext = {1'b0, CntW'(j_r)};

  assign cdiff = abs_diff(req_r.proposed_time, ctim_r[i_r]);
  assign chit = (CntW'(i_r) < ccnt_r) && (i_r != s_r) && cresp_r[i_r] &&
                (cdiff <= {16'd0, win_r});
  assign ddiff = abs_diff(dtim_r[i_r], dtim_r[j_r]);
  assign dhit = (CntW'(j_r) < dcnt_r) && (j_r > i_r) && dv_r[i_r] && dv_r[j_r] &&
                (ddiff <= {16'd0, win_r});

  always_comb begin
    c_found = 1'b0; c_match = '0; c_hasfree = 1'b0; c_free = '0;
    c_old = '0; best_el = seq_r - cage_r[0];
    d_found = 1'b0; d_match = '0; d_old = '0; dbest_el = seq_r - dage_r[0];
    nresp = '0; first = '0;
    el = '0; del = '0;
    for (int k = 0; k < PoolSize; k++) begin
      if (CntW'(k) < ccnt_r) begin
        if (!c_found && cv_r[k] && csrc_r[k] == req_r.src_key) begin
          c_found = 1'b1; c_match = IdxW'(k);
        end
        if (!c_hasfree && !cv_r[k]) begin
          c_hasfree = 1'b1; c_free = IdxW'(k);
        end
        el = seq_r - cage_r[k];
        if (k > 0 && el > best_el) begin
          best_el = el; c_old = IdxW'(k);
        end
        if (cresp_r[k]) begin
          if (nresp == '0) first = IdxW'(k);
          nresp = nresp + 1'b1;
        end
      end
      if (CntW'(k) < dcnt_r) begin
        if (!d_found && dv_r[k] && dsrc_r[k] == req_r.src_key) begin
          d_found = 1'b1; d_match = IdxW'(k);
        end
        del = seq_r - dage_r[k];
        if (k > 0 && del > dbest_el) begin
          dbest_el = del; d_old = IdxW'(k);
        end
      end
    end
  end

  assign sts.synced  = sync_r;
  assign sts.is_end  = (req_r.operation == OpEnd);
  assign sts.jump_ok = abs_diff(req_r.proposed_time, req_r.current_time) <= jump_r;
  assign sts.hit     = chit || dhit;
  assign sts.i_last  = (i_ext + 1'b1) >= {1'b0, (cmd.dist_scan ? dcnt_r : ccnt_r)};
  assign sts.j_last  = (j_ext + 1'b1) >= {1'b0, dcnt_r};
  assign sts.thr_met = rej_r >= thr_r;
  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 16'd60; jump_r <= 32'd3600; thr_r <= 8'd3;
      cv_r <= '0; cresp_r <= '0; cdist_r <= '0; ccnt_r <= '0;
      dv_r <= '0; dcnt_r <= '0; rej_r <= '0; att_r <= '0;
      sync_r <= 1'b0; seq_r <= '0; i_r <= '0; j_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_data.index)
          CfgWindow:    win_r <= cfg_data.data[15:0];
          CfgMaxJump:   jump_r <= cfg_data.data;
          CfgThreshold: thr_r <= cfg_data.data[7:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        req_r <= in_data;
        res_r <= '{set_clock: 1'b0, clock_value: 32'd0, is_synced: sync_r,
                   status: ST_WAITING};
      end
      if (cmd.clr_idx) begin
        i_r <= '0;
        j_r <= IdxW'(1);
      end
      if (cmd.adjust) begin
        res_r <= '{1'b1, req_r.proposed_time, 1'b1, ST_ADJUSTED};
      end
      if (cmd.cand_slot) begin
        logic [IdxW-1:0] s;
        s = c_found ? c_match : c_hasfree ? c_free :
            (ccnt_r < CntW'(PoolSize)) ? IdxW'(ccnt_r) : c_old;
        // A known source keeps its age and distrust mark.
        if (!c_found) begin
          if (!c_hasfree && ccnt_r < CntW'(PoolSize)) ccnt_r <= ccnt_r + 1'b1;
          csrc_r[s] <= req_r.src_key;
          cage_r[s] <= seq_r;
          seq_r <= seq_r + 16'd1;
          cdist_r[s] <= 1'b0;
        end
        cv_r[s] <= 1'b1;
        cresp_r[s] <= 1'b1;
        ctim_r[s] <= req_r.proposed_time;
        s_r <= s;
        res_r.status <= ST_STORED;
      end
      if (cmd.cand_scan) begin
        if (chit) begin
          res_r <= '{1'b1,
            (req_r.proposed_time <= ctim_r[i_r]) ? req_r.proposed_time : ctim_r[i_r],
            1'b1, ST_PAIR};
          sync_r <= 1'b1;
          cv_r <= '0; cresp_r <= '0; cdist_r <= '0; ccnt_r <= '0;
        end
        if (cmd.step_i) i_r <= i_r + 1'b1;
      end
      if (cmd.cand_mark) begin
        if ((CntW'(i_r) < ccnt_r) && i_r != s_r && cresp_r[i_r]) begin
          cdist_r[i_r] <= 1'b1;
          cdist_r[s_r] <= 1'b1;
        end
        i_r <= i_r + 1'b1;
      end
      if (cmd.dist_slot) begin
        logic [IdxW-1:0] s;
        s = d_found ? d_match : (dcnt_r < CntW'(PoolSize)) ? IdxW'(dcnt_r) : d_old;
        if (rej_r != 8'd255) rej_r <= rej_r + 8'd1;
        if (!d_found) begin
          if (dcnt_r < CntW'(PoolSize)) dcnt_r <= dcnt_r + 1'b1;
          dv_r[s] <= 1'b1;
          dsrc_r[s] <= req_r.src_key;
          dage_r[s] <= seq_r;
          seq_r <= seq_r + 16'd1;
        end
        dtim_r[s] <= req_r.proposed_time;
      end
      if (cmd.dist_scan) begin
        if (dhit) begin
          res_r <= '{1'b1, (dtim_r[i_r] <= dtim_r[j_r]) ? dtim_r[i_r] : dtim_r[j_r],
                     1'b1, ST_RESEEDED};
          dv_r <= '0; dcnt_r <= '0; rej_r <= '0;
        end else if (cmd.step_i) begin
          i_r <= i_r + 1'b1;
          j_r <= i_r + IdxW'(2);
        end else if (cmd.step_j) begin
          j_r <= j_r + 1'b1;
        end
      end
      if (cmd.reject) begin
        res_r.status <= ST_REJECTED;
      end
      if (cmd.eoa) begin
        if (att_r != 8'd255) att_r <= att_r + 8'd1;
        if (nresp == CntW'(1) && att_r >= 8'd1) begin
          if (!cdist_r[first]) begin
            res_r <= '{1'b1, ctim_r[first], 1'b1, ST_SINGLE};
            sync_r <= 1'b1;
            cv_r <= '0; cresp_r <= '0; cdist_r <= '0; ccnt_r <= '0;
          end else begin
            res_r.status <= ST_WITHHELD;
          end
        end
      end
    end
  end

  `TSCV_ASSERT_NXT(a_sync_stick, sync_r, sync_r)
  `TSCV_ASSERT_IMP(a_ccnt, 1'b1, ccnt_r <= CntW'(PoolSize))
  `TSCV_ASSERT_NXT(a_pair_clr, cmd.cand_scan && chit, ccnt_r == '0 && sync_r)
endmodule

>>> hw/rtl/time_source_consensus_voter.sv
// Channel  | dir | payload
// in_      | in  | operation, src_key, proposed_time, current_time
// out_     | out | set_clock, clock_value, is_synced, status
// cfg_     | in  | index (0 window, 1 max jump, 2 threshold), data
// One request at a time: the time from accept to the next accept is set by the
// pool scans (one candidate or one distrust pair per cycle), the output state
// and the idle state.
// Reset (rst_n low, synchronous) clears pools, counters and sync flag.
// A stalled result holds the block; config is always taken.
module time_source_consensus_voter (
  input logic clk,
  input logic rst_n,
  tscv_in_if.sink    in_ch,
  tscv_out_if.source out_ch,
  tscv_cfg_if.sink   cfg_ch
);
  import tscv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  tscv_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  tscv_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_ch.data),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .cmd(cmd), .sts(sts), .out_data(out_ch.data)
  );
endmodule
